### hdl/scd_pkg.sv
// ----------------------------------------------------------------------------
// scd_pkg: shared types and constants for the start-code deframer
// Holds the framing phase, status codes, and the record that passes from
// the front classifier to the back emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package scd_pkg;

    // Byte values that the parser looks for
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;
    localparam logic [7:0] BYTE_EPB  = 8'h03;

    // Held zeros and zero run both saturate at two
    localparam logic [1:0] HOLD_MAX = 2'd2;

    // Default depth of the queue between front and back
    localparam int FIFO_DEPTH_DEF = 4;

    // Phase of the leading start code search
    typedef enum logic [1:0] {
        PH_ZERO0,
        PH_ZERO1,
        PH_ONE,
        PH_UNIT
    } t_phase;

    // Packet status reported on the packet_end result
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_START    = 2'd1,
        ST_TRAIL_START = 2'd2
    } t_status;

    // One classified input byte: zeros to emit, then maybe the byte itself
    typedef struct packed {
        logic [1:0] zero_cnt;
        logic       emit_byte;
        logic [7:0] data;
        logic       last;
        t_status    status;
    } t_rec;

endpackage

`default_nettype wire

### hdl/scd_front.sv
// ----------------------------------------------------------------------------
// scd_front: byte classifier
// Tracks the leading start code, held zeros, zero run and packet status, and
// turns each accepted byte with a result into one record for the back emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module scd_front import scd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output      logic       o_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_packet_last,
    input  wire logic       i_q_ready,
    output      logic       o_push,
    output      t_rec       o_rec
);

    t_phase     r_phase, n_phase;
    t_status    r_err,   n_err;
    logic [1:0] r_held,  n_held;
    logic [1:0] r_zrun,  n_zrun;

    logic       w_accept;
    logic [1:0] w_zcnt;
    logic       w_emit;
    t_status    w_status;

    assign o_ready  = i_q_ready;
    assign w_accept = i_valid && i_q_ready;

    // Hold state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_ZERO0;
            r_err   <= ST_OK;
            r_held  <= 2'd0;
            r_zrun  <= 2'd0;
        end else begin
            r_phase <= n_phase;
            r_err   <= n_err;
            r_held  <= n_held;
            r_zrun  <= n_zrun;
        end
    end

    // Classify the byte and advance the parser
    always_comb begin
        n_phase  = r_phase;
        n_err    = r_err;
        n_held   = r_held;
        n_zrun   = r_zrun;
        w_zcnt   = 2'd0;
        w_emit   = 1'b0;
        w_status = ST_OK;
        if (w_accept) begin
            if (r_err != ST_OK) begin
                // failed packet: ignore bytes until its end
            end else if (r_phase != PH_UNIT) begin
                if (i_in_byte != ((r_phase == PH_ONE) ? BYTE_ONE : BYTE_ZERO)) begin
                    n_err = ST_NO_START;
                end else begin
                    case (r_phase)
                        PH_ZERO0: n_phase = PH_ZERO1;
                        PH_ZERO1: n_phase = PH_ONE;
                        PH_ONE:   n_phase = PH_UNIT;
                        default:  n_phase = r_phase;
                    endcase
                    if (i_packet_last) begin
                        n_err = (r_phase == PH_ONE) ? ST_TRAIL_START : ST_NO_START;
                    end
                end
            end else if (i_in_byte == BYTE_ZERO) begin
                // hold the zero; pass the oldest one on when two are held
                if (r_held == HOLD_MAX) begin
                    w_zcnt = 2'd1;
                end else begin
                    n_held = r_held + 2'd1;
                end
                if (r_zrun != HOLD_MAX) begin
                    n_zrun = r_zrun + 2'd1;
                end
            end else if (i_in_byte == BYTE_ONE && r_held == HOLD_MAX) begin
                // start code: drop held zeros and open a new unit
                n_held = 2'd0;
                n_zrun = 2'd0;
                if (i_packet_last) begin
                    n_err = ST_TRAIL_START;
                end
            end else begin
                // flush held zeros, then the byte unless it is an escape
                w_zcnt = r_held;
                w_emit = !(i_in_byte == BYTE_EPB && r_zrun == HOLD_MAX);
                n_held = 2'd0;
                n_zrun = 2'd0;
            end

            // Flush at packet end and return to the idle state
            if (i_packet_last) begin
                if (n_err == ST_OK) begin
                    w_zcnt = w_zcnt + n_held;
                end
                w_status = n_err;
                n_phase  = PH_ZERO0;
                n_err    = ST_OK;
                n_held   = 2'd0;
                n_zrun   = 2'd0;
            end
        end
    end

    // Push only records that produce at least one result
    assign o_push = w_accept && (i_packet_last || w_zcnt != 2'd0 || w_emit);

    assign o_rec.zero_cnt  = w_zcnt;
    assign o_rec.emit_byte = w_emit;
    assign o_rec.data      = i_in_byte;
    assign o_rec.last      = i_packet_last;
    assign o_rec.status    = w_status;

    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held != 2'd3)
        else $error("held zero count above two");

    a_zrun_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_zrun != 2'd3)
        else $error("zero run above two");

endmodule

`default_nettype wire

### hdl/scd_fifo.sv
// ----------------------------------------------------------------------------
// scd_fifo: record queue between front and back
// Small register queue; the head is presented combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module scd_fifo import scd_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_rec i_data,
    output      logic o_ready,
    output      logic o_valid,
    output      t_rec o_data,
    input  wire logic i_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_rec          r_mem [DEPTH];
    logic [AW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;

    assign o_ready = (r_count != FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];

    // Write entry at the tail
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == FULL_CNT |-> !i_push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> !i_pop)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

### hdl/scd_back.sv
// ----------------------------------------------------------------------------
// scd_back: result emitter
// Expands each queued record into its results, one per cycle unless
// i_ready stalls it, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module scd_back import scd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_q_valid,
    input  wire t_rec       i_rec,
    output      logic       o_pop,
    output      logic       o_valid,
    input  wire logic       i_ready,
    output      logic [7:0] o_out_byte,
    output      logic       o_byte_valid,
    output      logic       o_packet_end,
    output      logic [1:0] o_packet_status
);

    logic [1:0] r_idx, n_idx;
    logic       r_valid, n_valid;
    logic [7:0] r_byte,  n_byte;
    logic       r_bval,  n_bval;
    logic       r_end,   n_end;
    logic [1:0] r_stat,  n_stat;

    logic       w_load;
    logic       w_final;

    assign w_load = i_q_valid && (!r_valid || i_ready);

    // Hold control and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_bval <= n_bval;
        r_end  <= n_end;
        r_stat <= n_stat;
    end

    // Pick the next result of the head record
    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        n_byte  = r_byte;
        n_bval  = r_bval;
        n_end   = r_end;
        n_stat  = r_stat;
        if (i_rec.emit_byte) begin
            w_final = (r_idx == i_rec.zero_cnt);
        end else if (i_rec.zero_cnt == 2'd0) begin
            w_final = 1'b1;
        end else begin
            w_final = (r_idx == i_rec.zero_cnt - 2'd1);
        end

        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        if (w_load) begin
            n_valid = 1'b1;
            if (r_idx < i_rec.zero_cnt) begin
                n_byte = BYTE_ZERO;
                n_bval = 1'b1;
            end else if (i_rec.emit_byte) begin
                n_byte = i_rec.data;
                n_bval = 1'b1;
            end else begin
                n_byte = BYTE_ZERO;
                n_bval = 1'b0;
            end
            n_end  = w_final && i_rec.last;
            n_stat = (w_final && i_rec.last) ? i_rec.status : ST_OK;
            n_idx  = w_final ? 2'd0 : r_idx + 2'd1;
        end
    end

    assign o_pop           = w_load && w_final;
    assign o_valid         = r_valid;
    assign o_out_byte      = r_byte;
    assign o_byte_valid    = r_bval;
    assign o_packet_end    = r_end;
    assign o_packet_status = r_stat;

    a_status_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_stat != ST_OK |-> r_end)
        else $error("status reported off packet end");

endmodule

`default_nettype wire

### hdl/start_code_deframer_unescape.sv
// ----------------------------------------------------------------------------
// start_code_deframer_unescape: start-code deframer with 03 removal
// Top level: front classifier, record queue and back emitter.
// ----------------------------------------------------------------------------
// The block accepts one raw byte per clock and strips the 00 00 01 start
// codes and the emulation-prevention 03 bytes, delivering one result per
// clock on the output while i_ready is high. A byte that yields two or three
// results (held zeros flushed ahead of it, or at packet end) occupies the
// output for each of them in turn; a queue of FIFO_DEPTH records between
// classifier and emitter absorbs these bursts, and input stalls only when it
// fills. The first result of a byte passes through the queue register and
// then the emitter's registered output stage before o_valid rises. A packet
// whose last result carries a nonzero packet_status must be discarded by the
// consumer: 1 means no leading start code, 2 a start code with nothing
// after it at the packet end.
`default_nettype none

module start_code_deframer_unescape import scd_pkg::*; #(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output      logic       o_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_packet_last,
    output      logic       o_valid,
    input  wire logic       i_ready,
    output      logic [7:0] o_out_byte,
    output      logic       o_byte_valid,
    output      logic       o_packet_end,
    output      logic [1:0] o_packet_status
);

    logic w_push, w_q_ready, w_q_valid, w_pop;
    t_rec w_push_rec, w_head_rec;

    scd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_in_byte     (i_in_byte),
        .i_packet_last (i_packet_last),
        .i_q_ready     (w_q_ready),
        .o_push        (w_push),
        .o_rec         (w_push_rec)
    );

    scd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_rec),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_data  (w_head_rec),
        .i_pop   (w_pop)
    );

    scd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_rec           (w_head_rec),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_packet_end    (o_packet_end),
        .o_packet_status (o_packet_status)
    );

endmodule

`default_nettype wire
